// ----- rtl/ctzf_pkg.sv -----
package ctzf_pkg;

  localparam int ANTENNAS     = 64;
  localparam int CHANNELS     = 16;
  localparam int TIME_SAMPLES = 64;

  localparam int FRAME_WORDS = ANTENNAS * CHANNELS * TIME_SAMPLES;
  localparam int ADDR_W      = $clog2(FRAME_WORDS);

  // Field widths of the stream beats.
  localparam int ANT_W  = 6;
  localparam int CHAN_W = 4;
  localparam int TIME_W = 6;
  localparam int WORD_W = 32;

  localparam int DATA_W = ANT_W + CHAN_W + TIME_W + WORD_W;

  // Request kinds carried on in_tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic [ANT_W-1:0]  antenna;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] time_idx;
    logic              present;
    logic              last;
  } drain_meta_t;

endpackage

// ----- rtl/corner_turn_zero_fill_core.sv -----
// Corner-turn buffer: write beats (in_tuser low) store one 32-bit sample at an
// antenna, channel and time index and mark that antenna present; drain beats
// (in_tuser high) return the frame time-major, then channel, with antenna
// varying fastest, giving zero for antennas not written in this frame. The
// block takes one beat every clock cycle unless out_tready stalls the output.
// A drain result passes through the registered read of the single-port sample
// memory and then the output register. The sample memory is not cleared
// after reset, so a present antenna must have had every position it is
// drained at written at least once. The last word of a frame carries
// out_tlast; presence flags and the drain position clear on its acceptance.
module corner_turn_zero_fill_core
  import ctzf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  // antenna_index[5:0], chan_num[9:6], time_slot[15:10], sample_word[47:16]
  input  logic [DATA_W-1:0] in_tdata,
  // req_type
  input  logic              in_tuser,

  output logic              out_tvalid,
  input  logic              out_tready,
  // out_word[31:0], out_antenna[37:32], out_channel[41:38], out_time[47:42]
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic [ANT_W-1:0]  in_ant;
  logic [CHAN_W-1:0] in_chan;
  logic [TIME_W-1:0] in_time;
  logic [WORD_W-1:0] in_word;

  assign in_ant  = in_tdata[ANT_W-1:0];
  assign in_chan = in_tdata[ANT_W+CHAN_W-1:ANT_W];
  assign in_time = in_tdata[ANT_W+CHAN_W+TIME_W-1:ANT_W+CHAN_W];
  assign in_word = in_tdata[DATA_W-1:ANT_W+CHAN_W+TIME_W];

  logic [WORD_W-1:0] sample_mem [FRAME_WORDS];

  logic [ANTENNAS-1:0] present_r, present_nxt;
  logic [ANT_W-1:0]    ant_cnt_r, ant_cnt_nxt;
  logic [CHAN_W-1:0]   chan_cnt_r, chan_cnt_nxt;
  logic [TIME_W-1:0]   time_cnt_r, time_cnt_nxt;

  logic              s1_valid_r;
  drain_meta_t       s1_meta_r;
  logic [WORD_W-1:0] rd_word_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;

  logic adv_out, adv_s1, accept, wr_acc, drain_acc, in_range, last_pos;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign adv_out = !out_valid_r || out_tready;
  assign adv_s1  = !s1_valid_r || adv_out;
  assign in_tready = adv_s1;
  assign accept    = in_tvalid && in_tready;

  assign in_range = (int'(in_ant) < ANTENNAS) && (int'(in_chan) < CHANNELS) &&
                    (int'(in_time) < TIME_SAMPLES);
  assign wr_acc    = accept && (in_tuser == REQ_WRITE) && in_range;
  assign drain_acc = accept && (in_tuser == REQ_DRAIN);

  assign wr_addr = ADDR_W'((int'(in_time) * CHANNELS + int'(in_chan)) * ANTENNAS
                           + int'(in_ant));
  assign rd_addr = ADDR_W'((int'(time_cnt_r) * CHANNELS + int'(chan_cnt_r)) * ANTENNAS
                           + int'(ant_cnt_r));

  assign last_pos = (int'(ant_cnt_r) == ANTENNAS - 1) &&
                    (int'(chan_cnt_r) == CHANNELS - 1) &&
                    (int'(time_cnt_r) == TIME_SAMPLES - 1);

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      sample_mem[wr_addr] <= in_word;
    end
    if (drain_acc) begin
      rd_word_r <= sample_mem[rd_addr];
    end
  end

  always_comb begin
    present_nxt  = present_r;
    ant_cnt_nxt  = ant_cnt_r;
    chan_cnt_nxt = chan_cnt_r;
    time_cnt_nxt = time_cnt_r;
    if (wr_acc) begin
      present_nxt[in_ant] = 1'b1;
    end
    if (drain_acc) begin
      if (last_pos) begin
        present_nxt  = '0;
        ant_cnt_nxt  = '0;
        chan_cnt_nxt = '0;
        time_cnt_nxt = '0;
      end else if (int'(ant_cnt_r) != ANTENNAS - 1) begin
        ant_cnt_nxt = ant_cnt_r + 1'b1;
      end else begin
        ant_cnt_nxt = '0;
        if (int'(chan_cnt_r) != CHANNELS - 1) begin
          chan_cnt_nxt = chan_cnt_r + 1'b1;
        end else begin
          chan_cnt_nxt = '0;
          time_cnt_nxt = time_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      ant_cnt_r  <= '0;
      chan_cnt_r <= '0;
      time_cnt_r <= '0;
    end else begin
      present_r  <= present_nxt;
      ant_cnt_r  <= ant_cnt_nxt;
      chan_cnt_r <= chan_cnt_nxt;
      time_cnt_r <= time_cnt_nxt;
    end
  end

  // The read stage holds its word and position while the output is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= drain_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_acc) begin
      s1_meta_r.antenna  <= ant_cnt_r;
      s1_meta_r.channel  <= chan_cnt_r;
      s1_meta_r.time_idx <= time_cnt_r;
      s1_meta_r.present  <= present_r[ant_cnt_r];
      s1_meta_r.last     <= last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_data_r <= {s1_meta_r.time_idx, s1_meta_r.channel, s1_meta_r.antenna,
                     s1_meta_r.present ? rd_word_r : {WORD_W{1'b0}}};
      out_last_r <= s1_meta_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv_out) |=> ($stable(rd_word_r) && s1_valid_r))
    else $error("read stage changed while the output was stalled");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_acc && last_pos && !wr_acc) |=>
      (present_r == '0 && ant_cnt_r == '0 && chan_cnt_r == '0 && time_cnt_r == '0))
    else $error("presence or drain position not cleared after the last word");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (int'(out_data_r[WORD_W+ANT_W-1:WORD_W]) == ANTENNAS - 1 &&
       int'(out_data_r[DATA_W-1:WORD_W+ANT_W+CHAN_W]) == TIME_SAMPLES - 1))
    else $error("frame end flagged away from the final position");

endmodule
